@@ hw/rtl/rmf_pkg.sv @@
// Shared types and constants for the RGB median filter with reflect-101 borders.
// No dependencies.
`default_nettype none

package rmf_pkg;

	localparam int DEF_WINDOW    = 3;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int PIX_W         = 24;
	localparam int CH_W          = 8;
	localparam int ROW_W         = 13;
	localparam int IMG_W_W       = 11;
	localparam int IMG_H_W       = 13;
	localparam int MAX_HEIGHT    = 4096;
	localparam int CFG_DATA_W    = 13;
	localparam int MID_DEPTH     = 4;
	localparam int OUT_DEPTH     = 4;

	localparam logic [IMG_W_W-1:0] RESET_WIDTH  = IMG_W_W'(768);
	localparam logic [IMG_H_W-1:0] RESET_HEIGHT = IMG_H_W'(512);

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       last_of_run;
		logic       end_of_frame;
	} out_item_t;

	typedef struct packed {
		logic last_col;
		logic last_row;
	} mid_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/rmf_fifo.sv @@
// Small register FIFO, power-of-two depth, head always visible.
// No package dependencies.
`default_nettype none

module rmf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           din,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           dout,
	output logic      [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNTW'(1);
				2'b01:   cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign dout  = mem_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

`default_nettype wire

@@ hw/rtl/rmf_front.sv @@
// Front end: size registers, raster position, line store banks and row-mirrored
// column vectors. Depends on rmf_pkg.
`default_nettype none

module rmf_front #(
	parameter int WINDOW    = rmf_pkg::DEF_WINDOW,
	parameter int MAX_WIDTH = rmf_pkg::DEF_MAX_WIDTH,
	parameter int QDEPTH    = rmf_pkg::MID_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire rmf_pkg::in_item_t                   item,
	input  wire logic                                wr_en,
	input  wire logic [0:0]                          wr_index,
	input  wire logic [rmf_pkg::CFG_DATA_W-1:0]      wr_data,
	input  wire logic [$clog2(QDEPTH+1)-1:0]         q_cnt,
	output logic                                     mid_push,
	output logic [WINDOW*rmf_pkg::PIX_W-1:0]         mid_vec,
	output logic [$clog2(MAX_WIDTH)-1:0]             mid_col,
	output rmf_pkg::mid_flags_t                      mid_flags,
	output logic [$clog2(MAX_WIDTH+1)-1:0]           w_eff
);

	localparam int PAD  = WINDOW / 2;
	localparam int PW   = rmf_pkg::PIX_W;
	localparam int SW   = $clog2(WINDOW);
	localparam int SXW  = $clog2(2*WINDOW);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH+1);
	localparam int RW   = rmf_pkg::ROW_W;
	localparam int TW   = RW + 2;
	localparam int WCMP = (WW > rmf_pkg::IMG_W_W) ? WW : rmf_pkg::IMG_W_W;
	localparam int QCW  = $clog2(QDEPTH+1);

	logic [rmf_pkg::IMG_W_W-1:0] width_q;
	logic [rmf_pkg::IMG_H_W-1:0] height_q;
	logic [RW-1:0]               row_q;
	logic [CW-1:0]               col_q;
	logic [SW-1:0]               slot_q;

	logic [WCMP-1:0] wx;
	logic [RW-1:0]   h_eff;
	logic            accept, drain_row, act, wr, last_col, emit;
	logic [RW-1:0]   row_nxt;
	logic [PW-1:0]   pix;
	logic [QCW:0]    occ;

	logic [SW-1:0]   lane_slot [WINDOW];
	logic            lane_byp  [WINDOW];

	logic                 v_s1;
	logic [SW-1:0]        slot_s1 [WINDOW];
	logic                 byp_s1  [WINDOW];
	logic [PW-1:0]        pix_s1;
	logic [CW-1:0]        col_s1;
	rmf_pkg::mid_flags_t  flags_s1;
	logic [PW-1:0]        rd_s1   [WINDOW];

	always_comb begin
		wx = WCMP'(width_q);
		if (wx < WCMP'(PAD+1))          w_eff = WW'(PAD+1);
		else if (wx > WCMP'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else                            w_eff = WW'(wx);
		if (height_q < RW'(PAD+1))                   h_eff = RW'(PAD+1);
		else if (height_q > RW'(rmf_pkg::MAX_HEIGHT)) h_eff = RW'(rmf_pkg::MAX_HEIGHT);
		else                                          h_eff = height_q;
	end

	assign occ       = {1'b0, q_cnt} + (QCW+1)'(v_s1);
	assign full      = occ >= (QCW+1)'(QDEPTH);
	assign accept    = push && !full;
	assign drain_row = row_q >= h_eff;
	assign act       = accept && !(!drain_row && item.req_type == rmf_pkg::REQ_DRAIN);
	assign wr        = act && !drain_row;
	assign last_col  = col_q == CW'(w_eff - WW'(1));
	assign emit      = act && (row_q >= RW'(PAD));
	assign row_nxt   = row_q + RW'(1);
	assign pix       = {item.in_red, item.in_green, item.in_blue};

	// per window row: which bank holds the mirrored source row
	always_comb begin
		logic signed [TW-1:0] t, hm1, rs, d;
		logic [SXW-1:0]       s;
		hm1 = $signed({2'b00, h_eff}) - TW'(1);
		rs  = $signed({2'b00, row_q});
		for (int i = 0; i < WINDOW; i++) begin
			t = rs + TW'(i) - TW'(2*PAD);
			if (t < 0)   t = -t;
			if (t > hm1) t = (hm1 <<< 1) - t;
			if (t < 0)   t = '0;
			if (t > hm1) t = hm1;
			d = rs - t;
			s = SXW'(slot_q) + SXW'(WINDOW) - SXW'(d);
			if (s >= SXW'(WINDOW)) s = s - SXW'(WINDOW);
			lane_slot[i] = SW'(s);
			lane_byp[i]  = (d == '0) && !drain_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= rmf_pkg::RESET_WIDTH;
			height_q <= rmf_pkg::RESET_HEIGHT;
			row_q    <= '0;
			col_q    <= '0;
			slot_q   <= '0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= emit;
			if (wr_en) begin
				unique case (rmf_pkg::reg_idx_t'(wr_index))
					rmf_pkg::REG_IMAGE_WIDTH:  width_q  <= wr_data[rmf_pkg::IMG_W_W-1:0];
					rmf_pkg::REG_IMAGE_HEIGHT: height_q <= wr_data;
					default: ;
				endcase
				row_q  <= '0;
				col_q  <= '0;
				slot_q <= '0;
			end else if (act) begin
				if (last_col) begin
					col_q <= '0;
					if (row_nxt == h_eff + RW'(PAD)) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= row_nxt;
						slot_q <= (slot_q == SW'(WINDOW-1)) ? '0 : slot_q + SW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int i = 0; i < WINDOW; i++) begin
				slot_s1[i] <= lane_slot[i];
				byp_s1[i]  <= lane_byp[i];
			end
			pix_s1            <= pix;
			col_s1            <= col_q;
			flags_s1.last_col <= last_col;
			flags_s1.last_row <= row_q == h_eff - RW'(1) + RW'(PAD);
		end
	end

	for (genvar b = 0; b < WINDOW; b++) begin : g_bank
		logic [PW-1:0] mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (wr && slot_q == SW'(b)) begin
				mem[col_q] <= pix;
			end
			if (act) begin
				rd_s1[b] <= mem[col_q];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WINDOW; i++) begin
			mid_vec[i*PW +: PW] = byp_s1[i] ? pix_s1 : rd_s1[slot_s1[i]];
		end
	end

	assign mid_push  = v_s1;
	assign mid_col   = col_s1;
	assign mid_flags = flags_s1;

endmodule

`default_nettype wire

@@ hw/rtl/rmf_back.sv @@
// Back end: column history, result sequencer with column mirroring, and a
// two-stage rank-select median per channel. Depends on rmf_pkg.
`default_nettype none

module rmf_back #(
	parameter int WINDOW    = rmf_pkg::DEF_WINDOW,
	parameter int MAX_WIDTH = rmf_pkg::DEF_MAX_WIDTH,
	parameter int ODEPTH    = rmf_pkg::OUT_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  wire logic [WINDOW*rmf_pkg::PIX_W-1:0]    q_vec,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]        q_col,
	input  wire rmf_pkg::mid_flags_t                 q_flags,
	output logic                                     q_pop,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]      w_eff,
	input  wire logic [$clog2(ODEPTH+1)-1:0]         out_cnt,
	output logic                                     res_push,
	output rmf_pkg::out_item_t                       res
);

	localparam int PAD  = WINDOW / 2;
	localparam int TAPS = WINDOW * WINDOW;
	localparam int PW   = rmf_pkg::PIX_W;
	localparam int CHW  = rmf_pkg::CH_W;
	localparam int SW   = $clog2(WINDOW);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH+1);
	localparam int TW   = WW + 2;
	localparam int OCW  = $clog2(ODEPTH+1);

	logic [WINDOW*PW-1:0] hist_q [WINDOW];
	logic                 busy_q, erow_last_q;
	logic [CW-1:0]        cur_c_q, end_c_q, ecol_q;

	logic          credit, issue, done, emit_norm, has;
	logic [CW-1:0] wm1, c0, cend;
	logic [OCW:0]  occ;
	logic [PW-1:0] win [TAPS];

	logic          v_s1, v_s2;
	logic [PW-1:0] win_s1 [TAPS];
	logic          lor_s1, eof_s1, lor_s2, eof_s2;
	logic [PW-1:0] win_s2 [TAPS];
	logic [TAPS-1:0] cmp_s2 [3][TAPS];
	logic [CHW-1:0]  med [3];

	assign wm1       = CW'(w_eff - WW'(1));
	assign occ       = {1'b0, out_cnt} + (OCW+1)'(v_s1) + (OCW+1)'(v_s2);
	assign credit    = occ < (OCW+1)'(ODEPTH);
	assign issue     = busy_q && credit;
	assign done      = issue && (cur_c_q == end_c_q);
	assign q_pop     = !q_empty && (!busy_q || done);
	assign emit_norm = q_col >= CW'(PAD);
	assign has       = emit_norm || q_flags.last_col;
	assign c0        = emit_norm ? q_col - CW'(PAD) : CW'(w_eff - WW'(PAD));
	assign cend      = q_flags.last_col ? wm1 : q_col - CW'(PAD);

	// column mirroring into the history taps; hist_q[0] is the newest column
	always_comb begin
		logic signed [TW-1:0] t, wmx, off;
		wmx = $signed({2'b00, w_eff}) - TW'(1);
		for (int k = 0; k < WINDOW; k++) begin
			t = $signed(TW'({2'b00, cur_c_q})) + TW'(k) - TW'(PAD);
			if (t < 0)   t = -t;
			if (t > wmx) t = (wmx <<< 1) - t;
			if (t < 0)   t = '0;
			if (t > wmx) t = wmx;
			off = $signed(TW'({2'b00, ecol_q})) - t;
			for (int dy = 0; dy < WINDOW; dy++) begin
				win[dy*WINDOW + k] = hist_q[SW'(off)][dy*PW +: PW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (q_pop)     busy_q <= has;
			else if (done) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hist_q[0] <= q_vec;
			for (int k = 1; k < WINDOW; k++) hist_q[k] <= hist_q[k-1];
			cur_c_q     <= c0;
			end_c_q     <= cend;
			ecol_q      <= q_col;
			erow_last_q <= q_flags.last_row;
		end else if (issue) begin
			cur_c_q <= cur_c_q + CW'(1);
		end
		if (issue) begin
			for (int i = 0; i < TAPS; i++) win_s1[i] <= win[i];
			lor_s1 <= cur_c_q == end_c_q;
			eof_s1 <= erow_last_q && (cur_c_q == wm1);
		end
		if (v_s1) begin
			for (int c = 0; c < 3; c++) begin
				for (int i = 0; i < TAPS; i++) begin
					for (int j = 0; j < TAPS; j++) begin
						cmp_s2[c][i][j] <= (win_s1[j][c*CHW +: CHW] < win_s1[i][c*CHW +: CHW]) ||
							(win_s1[j][c*CHW +: CHW] == win_s1[i][c*CHW +: CHW] && j < i);
					end
				end
			end
			for (int i = 0; i < TAPS; i++) win_s2[i] <= win_s1[i];
			lor_s2 <= lor_s1;
			eof_s2 <= eof_s1;
		end
	end

	// the median is the sample with exactly TAPS/2 samples ranked below it
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			med[c] = '0;
			for (int i = 0; i < TAPS; i++) begin
				if ($countones(cmp_s2[c][i]) == TAPS/2) med[c] = med[c] | win_s2[i][c*CHW +: CHW];
			end
		end
	end

	assign res_push         = v_s2;
	assign res.out_red      = med[2];
	assign res.out_green    = med[1];
	assign res.out_blue     = med[0];
	assign res.last_of_run  = lor_s2;
	assign res.end_of_frame = eof_s2;

endmodule

`default_nettype wire

@@ hw/rtl/rgb_median_filter_reflect_unit.sv @@
// Top level of the streaming RGB median filter with reflect-101 borders.
// Depends on rmf_pkg, rmf_front, rmf_fifo, rmf_back.
//
// Takes one pixel or drain beat per clock while full is low and returns per-channel
// WINDOW x WINDOW medians in raster order, lagging by WINDOW/2 rows and columns.
// Results leave at one per cycle from the back-end window mux while the output
// queue has room, so a last-column beat, which yields WINDOW/2+1 results, keeps
// the back end busy until its last result is issued, and input stalls once the
// middle queue has filled. The line store is WINDOW banks of MAX_WIDTH pixels
// with no clearing pass.
// Size writes restart the frame and must only be made while the block is idle.
`default_nettype none

module rgb_median_filter_reflect_unit #(
	parameter int WINDOW    = rmf_pkg::DEF_WINDOW,
	parameter int MAX_WIDTH = rmf_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire rmf_pkg::in_item_t              item,
	output logic                                empty,
	input  wire logic                           pop,
	output rmf_pkg::out_item_t                  result,
	input  wire logic                           wr_en,
	input  wire logic [0:0]                     wr_index,
	input  wire logic [rmf_pkg::CFG_DATA_W-1:0] wr_data
);

	localparam int PW   = rmf_pkg::PIX_W;
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH+1);
	localparam int FW   = $bits(rmf_pkg::mid_flags_t);
	localparam int MW   = WINDOW*PW + CW + FW;
	localparam int MQ   = rmf_pkg::MID_DEPTH;
	localparam int OQ   = rmf_pkg::OUT_DEPTH;
	localparam int OW   = $bits(rmf_pkg::out_item_t);

	logic                    mid_push, mid_pop;
	logic [WINDOW*PW-1:0]    mid_vec, q_vec;
	logic [CW-1:0]           mid_col, q_col;
	rmf_pkg::mid_flags_t     mid_flags, q_flags;
	logic [MW-1:0]           q_dout;
	logic [$clog2(MQ+1)-1:0] q_cnt;
	logic [WW-1:0]           w_eff;
	logic                    res_push;
	rmf_pkg::out_item_t      res;
	logic [OW-1:0]           o_dout;
	logic [$clog2(OQ+1)-1:0] o_cnt;

	rmf_front #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH), .QDEPTH(MQ)) u_front (
		.clk, .arst_n, .push, .full, .item, .wr_en, .wr_index, .wr_data,
		.q_cnt, .mid_push, .mid_vec, .mid_col, .mid_flags, .w_eff
	);

	rmf_fifo #(.WIDTH(MW), .DEPTH(MQ)) u_mid_q (
		.clk, .arst_n, .push(mid_push), .din({mid_vec, mid_col, mid_flags}),
		.pop(mid_pop), .dout(q_dout), .count(q_cnt)
	);

	assign q_vec   = q_dout[MW-1 -: WINDOW*PW];
	assign q_col   = q_dout[FW +: CW];
	assign q_flags = rmf_pkg::mid_flags_t'(q_dout[FW-1:0]);

	rmf_back #(.WINDOW(WINDOW), .MAX_WIDTH(MAX_WIDTH), .ODEPTH(OQ)) u_back (
		.clk, .arst_n, .q_empty(q_cnt == '0), .q_vec, .q_col, .q_flags,
		.q_pop(mid_pop), .w_eff, .out_cnt(o_cnt), .res_push, .res
	);

	rmf_fifo #(.WIDTH(OW), .DEPTH(OQ)) u_out_q (
		.clk, .arst_n, .push(res_push), .din(res), .pop(pop && !empty),
		.dout(o_dout), .count(o_cnt)
	);

	assign empty  = o_cnt == '0;
	assign result = rmf_pkg::out_item_t'(o_dout);

endmodule

`default_nettype wire
